// ===== rtl/core/qtl_pkg.sv =====
`timescale 1ns / 1ps
package qtl_pkg;

	typedef enum logic [3:0] {
		S_IDLE   = 4'd0,
		S_INT    = 4'd1,
		S_FRAC   = 4'd2,
		S_DOT    = 4'd3,
		S_EXP    = 4'd4,
		S_EXPDIG = 4'd5,
		S_STR    = 4'd6,
		S_STRESC = 4'd7,
		S_OP2    = 4'd8,
		S_IDENT  = 4'd9
	} scan_state_t;

	typedef enum logic [2:0] {
		K_END    = 3'd0,
		K_INT    = 3'd1,
		K_FLOAT  = 3'd2,
		K_STRING = 3'd3,
		K_BOOL   = 3'd4,
		K_OP     = 3'd5,
		K_IDENT  = 3'd6,
		K_ERR    = 3'd7
	} tok_kind_t;

	typedef enum logic [2:0] {
		E_NONE     = 3'd0,
		E_BAD_EXP  = 3'd1,
		E_LONE_DOT = 3'd2,
		E_UNTERM   = 3'd3,
		E_INVALID  = 3'd4
	} err_code_t;

	typedef struct packed {
		tok_kind_t   kind;
		err_code_t   code;
		logic [15:0] start;
		logic [15:0] len;
	} tok_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} out_ent_t;

	localparam int TDATA_W = 40;

	function automatic tok_t mk_tok(tok_kind_t k, err_code_t c, logic [15:0] s,
			logic [15:0] l);
		tok_t t;
		t.kind  = k;
		t.code  = c;
		t.start = s;
		t.len   = l;
		return t;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return (b == " ") || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
	endfunction

	function automatic logic [7:0] to_upper(logic [7:0] b);
		return ((b >= "a") && (b <= "z")) ? b - 8'd32 : b;
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] b);
		return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
	endfunction

	// saturating span from token begin to an end offset
	function automatic logic [15:0] span_len(logic [16:0] end_pos, logic [15:0] tb);
		logic [16:0] d;
		d = (end_pos >= {1'b0, tb}) ? end_pos - {1'b0, tb} : 17'd0;
		return d[16] ? 16'hFFFF : d[15:0];
	endfunction

	function automatic logic is_single_op(logic [7:0] b);
		return (b == "+") || (b == "-") || (b == "*") || (b == "/") || (b == "%") ||
			(b == "~") || (b == "^") || (b == ",") || (b == ";") || (b == "(") ||
			(b == ")") || (b == "[") || (b == "]");
	endfunction

	// 1..6 for & | < > = !, else 0
	function automatic logic [2:0] pair_code(logic [7:0] b);
		logic [2:0] c;
		unique case (b)
			"&":     c = 3'd1;
			"|":     c = 3'd2;
			"<":     c = 3'd3;
			">":     c = 3'd4;
			"=":     c = 3'd5;
			"!":     c = 3'd6;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pair_char(logic [2:0] c);
		logic [7:0] r;
		unique case (c)
			3'd1:    r = "&";
			3'd2:    r = "|";
			3'd3:    r = "<";
			3'd4:    r = ">";
			3'd5:    r = "=";
			3'd6:    r = "!";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// keyword walker: OR = 1, AND = 2,3, NOT = 4,5
	function automatic logic [7:0] kw_expect(logic [2:0] p);
		logic [7:0] r;
		unique case (p)
			3'd1:    r = "R";
			3'd2:    r = "N";
			3'd3:    r = "D";
			3'd4:    r = "O";
			3'd5:    r = "T";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] kw_next(logic [2:0] p);
		logic [2:0] r;
		unique case (p)
			3'd2:    r = 3'd3;
			3'd4:    r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] true_char(logic [1:0] i);
		logic [7:0] r;
		unique case (i)
			2'd0: r = "t";
			2'd1: r = "r";
			2'd2: r = "u";
			2'd3: r = "e";
		endcase
		return r;
	endfunction

	function automatic logic [7:0] false_char(logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0:    r = "f";
			3'd1:    r = "a";
			3'd2:    r = "l";
			3'd3:    r = "s";
			3'd4:    r = "e";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/qtl_scan.sv =====
`timescale 1ns / 1ps
module qtl_scan import qtl_pkg::*; #(
	parameter longint unsigned MAX_QUERY_LEN = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_query,
	output tok_t        res0,
	output tok_t        res1,
	output logic [1:0]  n_res
);

	localparam longint unsigned CAP_L =
		(MAX_QUERY_LEN - 1 < 65535) ? MAX_QUERY_LEN - 1 : 65535;
	localparam logic [15:0] POS_CAP = CAP_L[15:0];

	scan_state_t st_q, st;
	logic [15:0] tb_q, tb;
	logic [15:0] bp_q, bp;
	logic        qd_q, qd;
	logic [2:0]  oc_q, oc;
	logic [2:0]  kw_q, kw;
	logic [1:0]  bm_q, bm;

	tok_t        res [2];
	logic [1:0]  n;
	logic        used;
	logic [7:0]  pc;
	logic [16:0] bp_nxt;

	// boolean candidate tracking: bit0 true, bit1 false
	function automatic logic [1:0] upd_bool(logic [1:0] m_in, logic [7:0] b,
			logic [15:0] pos, logic [15:0] beg);
		logic [1:0]  m;
		logic [15:0] idx;
		logic [7:0]  lb;
		m   = m_in;
		idx = pos - beg;
		lb  = to_lower(b);
		if (pos >= POS_CAP || pos < beg)
			m = 2'b00;
		if (idx >= 16'd4 || lb != true_char(idx[1:0]))
			m[0] = 1'b0;
		if (idx >= 16'd5 || lb != false_char(idx[2:0]))
			m[1] = 1'b0;
		return m;
	endfunction

	// token left open when a byte does not extend it
	function automatic tok_t pend_tok(scan_state_t s, logic [1:0] m, logic [15:0] beg,
			logic [15:0] l);
		tok_t t;
		unique case (s)
			S_INT:            t = mk_tok(K_INT, E_NONE, beg, l);
			S_FRAC, S_EXPDIG: t = mk_tok(K_FLOAT, E_NONE, beg, l);
			S_DOT:            t = mk_tok(K_ERR, E_LONE_DOT, beg, l);
			S_EXP:            t = mk_tok(K_ERR, E_BAD_EXP, beg, l);
			S_STR, S_STRESC:  t = mk_tok(K_ERR, E_UNTERM, beg, l);
			S_OP2:            t = mk_tok(K_OP, E_NONE, beg, l);
			S_IDENT: begin
				if ((l == 16'd4 && m[0]) || (l == 16'd5 && m[1]))
					t = mk_tok(K_BOOL, E_NONE, beg, l);
				else
					t = mk_tok(K_IDENT, E_NONE, beg, l);
			end
			default:          t = mk_tok(K_END, E_NONE, beg, l);
		endcase
		return t;
	endfunction

	assign bp_nxt = {1'b0, bp_q} + 17'd1;

	always_comb begin
		st     = st_q;
		tb     = tb_q;
		bp     = bp_q;
		qd     = qd_q;
		oc     = oc_q;
		kw     = kw_q;
		bm     = bm_q;
		n      = 2'd0;
		res[0] = '0;
		res[1] = '0;
		used   = 1'b0;
		pc     = pair_char(oc_q);
		if (end_of_query) begin
			if (st_q != S_IDLE) begin
				res[n[0]] = pend_tok(st_q, bm_q, tb_q, span_len({1'b0, bp_q}, tb_q));
				n = n + 2'd1;
			end
			res[n[0]] = mk_tok(K_END, E_NONE, bp_q, 16'd0);
			n  = n + 2'd1;
			st = S_IDLE;
			kw = 3'd0;
			bm = 2'b00;
			oc = 3'd0;
			tb = 16'd0;
			bp = 16'd0;
			qd = 1'b0;
		end else begin
			// try to extend the open token
			unique case (st_q)
				S_INT: begin
					if (is_digit(data_byte)) begin
						used = 1'b1;
					end else if (data_byte == ".") begin
						st = S_FRAC; used = 1'b1;
					end else if (data_byte == "e" || data_byte == "E") begin
						st = S_EXP; used = 1'b1;
					end
				end
				S_DOT, S_FRAC: begin
					if (is_digit(data_byte)) begin
						st = S_FRAC; used = 1'b1;
					end else if (data_byte == "e" || data_byte == "E") begin
						st = S_EXP; used = 1'b1;
					end
				end
				S_EXP: begin
					if (data_byte == "+" || data_byte == "-" || is_digit(data_byte)) begin
						st = S_EXPDIG; used = 1'b1;
					end
				end
				S_EXPDIG: used = is_digit(data_byte);
				S_STR: begin
					used = 1'b1;
					if (data_byte == (qd_q ? 8'("\"") : 8'("'"))) begin
						res[n[0]] = mk_tok(K_STRING, E_NONE, tb_q, span_len(bp_nxt, tb_q));
						n  = n + 2'd1;
						st = S_IDLE; kw = 3'd0; bm = 2'b00; oc = 3'd0;
					end else if (data_byte == "\\") begin
						st = S_STRESC;
					end
				end
				S_STRESC: begin
					st = S_STR; used = 1'b1;
				end
				S_OP2: begin
					if (pc != 8'd0 && (data_byte == pc || (oc_q >= 3'd3 &&
							(data_byte == "=" || (pc == "<" && data_byte == ">"))))) begin
						res[n[0]] = mk_tok(K_OP, E_NONE, tb_q, span_len(bp_nxt, tb_q));
						n    = n + 2'd1;
						st   = S_IDLE; kw = 3'd0; bm = 2'b00; oc = 3'd0;
						used = 1'b1;
					end
				end
				S_IDENT: begin
					if (kw_q >= 3'd1 && kw_q <= 3'd5 &&
							to_upper(data_byte) == kw_expect(kw_q)) begin
						used = 1'b1;
						if (kw_next(kw_q) == 3'd0) begin
							res[n[0]] = mk_tok(K_OP, E_NONE, tb_q, span_len(bp_nxt, tb_q));
							n  = n + 2'd1;
							st = S_IDLE; kw = 3'd0; bm = 2'b00; oc = 3'd0;
						end else begin
							kw = kw_next(kw_q);
							bm = upd_bool(bm_q, data_byte, bp_q, tb_q);
						end
					end else begin
						kw = 3'd0;
						if (is_alpha(data_byte) || is_digit(data_byte)) begin
							bm   = upd_bool(bm_q, data_byte, bp_q, tb_q);
							used = 1'b1;
						end
					end
				end
				default: used = 1'b0;
			endcase

			if (!used) begin
				// close the open token, then start afresh with this byte
				if (st_q != S_IDLE) begin
					res[n[0]] = pend_tok(st_q, bm_q, tb_q, span_len({1'b0, bp_q}, tb_q));
					n = n + 2'd1;
				end
				st = S_IDLE; kw = 3'd0; bm = 2'b00; oc = 3'd0;
				if (!is_space(data_byte)) begin
					tb = bp_q;
					if (is_digit(data_byte)) begin
						st = S_INT;
					end else if (data_byte == ".") begin
						st = S_DOT;
					end else if (data_byte == "'" || data_byte == "\"") begin
						st = S_STR;
						qd = (data_byte == "\"");
					end else if (is_single_op(data_byte)) begin
						res[n[0]] = mk_tok(K_OP, E_NONE, bp_q, 16'd1);
						n = n + 2'd1;
					end else if (pair_code(data_byte) != 3'd0) begin
						st = S_OP2;
						oc = pair_code(data_byte);
					end else if (is_alpha(data_byte) || data_byte == "_") begin
						st = S_IDENT;
						unique case (to_upper(data_byte))
							"O":     kw = 3'd1;
							"A":     kw = 3'd2;
							"N":     kw = 3'd4;
							default: kw = 3'd0;
						endcase
						bm = upd_bool(2'b11, data_byte, bp_q, bp_q);
					end else begin
						res[n[0]] = mk_tok(K_ERR, E_INVALID, bp_q, 16'd1);
						n = n + 2'd1;
					end
				end
			end

			if (bp_q < POS_CAP)
				bp = bp_nxt[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			tb_q <= 16'd0;
			bp_q <= 16'd0;
			qd_q <= 1'b0;
			oc_q <= 3'd0;
			kw_q <= 3'd0;
			bm_q <= 2'b00;
		end else if (step) begin
			st_q <= st;
			tb_q <= tb;
			bp_q <= bp;
			qd_q <= qd;
			oc_q <= oc;
			kw_q <= kw;
			bm_q <= bm;
		end
	end

	assign res0  = res[0];
	assign res1  = res[1];
	assign n_res = n;

endmodule

// ===== rtl/core/qtl_out_fifo.sv =====
`timescale 1ns / 1ps
module qtl_out_fifo import qtl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  out_ent_t   push0,
	input  out_ent_t   push1,
	input  logic       pop,
	output out_ent_t   head,
	output logic       head_valid,
	output logic [2:0] count
);

	out_ent_t   mem [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wr_ptr_q] <= push0;
		if (push_n == 2'd2)
			mem[wr_ptr_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			cnt_q    <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	assign head       = mem[rd_ptr_q];
	assign head_valid = (cnt_q != 3'd0);
	assign count      = cnt_q;

endmodule

// ===== rtl/core/query_token_lexer.sv =====
`timescale 1ns / 1ps
// Query text tokenizer.
// Input stream (s_*): one query byte per beat in s_tdata; s_tlast high marks the
// end of the query (that beat carries no byte). Output stream (m_*): one token
// per beat, kind in m_tuser, error code / start offset / length in m_tdata;
// m_tlast marks the last token caused by one input beat.
// A byte is captured in an input register; the scanner then updates its state
// and writes 0, 1 or 2 tokens into a 4-entry output queue, once that queue has room.
// A token beat is driven from the queue, so a completing beat passes the input
// register and the queue register before m_tvalid rises.
// Throughput: one byte per clock while each byte yields at most one token and
// m_tready stays high; a byte that yields two tokens (pending token plus
// operator/error, or end of query flushing a token) puts both into the queue.
// The input register advances only when the queue holds two or fewer tokens.
// When the receiver stalls, tokens wait in the queue; the input side keeps
// taking bytes until three tokens wait, then s_tready drops.
// Reset clears the scanner to idle with offset zero; an end-of-query beat
// returns it to that same state for the next query.
// Offsets saturate at min(MAX_QUERY_LEN - 1, 65535).
module query_token_lexer import qtl_pkg::*; #(
	parameter longint unsigned MAX_QUERY_LEN = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic               s_tlast,   // end_of_query
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [2:0] error_code, [18:3] token_start,
	                                      // [34:19] token_length, [39:35] zero
	output logic [2:0]         m_tuser,   // [2:0] token_kind
	output logic               m_tlast    // last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoq_s1;
	logic       proc;
	logic       in_acc;

	tok_t       r0, r1;
	logic [1:0] n_res;
	out_ent_t   e0, e1, head;
	logic       head_valid;
	logic [2:0] q_count;

	// room for two tokens is needed before the held byte is scanned
	assign proc     = valid_s1 && (q_count <= 3'd2);
	assign s_tready = !valid_s1 || proc;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (proc)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= s_tdata;
			eoq_s1  <= s_tlast;
		end
	end

	qtl_scan #(
		.MAX_QUERY_LEN(MAX_QUERY_LEN)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (proc),
		.data_byte    (byte_s1),
		.end_of_query (eoq_s1),
		.res0         (r0),
		.res1         (r1),
		.n_res        (n_res)
	);

	assign e0.tok  = r0;
	assign e0.last = (n_res == 2'd1);
	assign e1.tok  = r1;
	assign e1.last = 1'b1;

	qtl_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (proc ? n_res : 2'd0),
		.push0      (e0),
		.push1      (e1),
		.pop        (m_tvalid && m_tready),
		.head       (head),
		.head_valid (head_valid),
		.count      (q_count)
	);

	assign m_tvalid = head_valid;
	assign m_tuser  = head.tok.kind;
	assign m_tdata  = {5'd0, head.tok.len, head.tok.start, head.tok.code};
	assign m_tlast  = head.last;

endmodule
